// ----- design/pee_pkg.sv -----
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Character codes, status codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam logic [7:0] CH_ADD = 8'h2B;
  localparam logic [7:0] CH_SUB = 8'h2D;
  localparam logic [7:0] CH_MUL = 8'h2A;
  localparam logic [7:0] CH_DIV = 8'h2F;
  localparam logic [7:0] CH_POW = 8'h5E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic       take;      // capture input character
    logic       digit;     // accumulate digit
    logic       flush;     // push pending number
    logic       pop_r;     // pop right operand
    logic       pop_l;     // pop left operand
    logic       start;     // start arithmetic
    logic       push_res;  // push arithmetic result
    logic       pop_ans;   // pop answer
    logic       clear;     // end of expression
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       busy;      // arithmetic unit working
    logic       skip_push; // division by zero
  } sts_t;

endpackage

// ----- design/postfix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates reverse Polish integer expressions one character at a time.
// ----------------------------------------------------------------------------
// Input channel: ch/last with in_valid/in_stall; one character per
// transaction, last marks the end of an expression.
// Output channel: answer/status with out_valid/out_stall; one transaction per
// expression, raised after the last character has been worked through.
// Digits and plain characters are captured and decoded. An operator pops two
// operands, runs the arithmetic (one quotient bit a cycle in the iterative
// divider for /, one exponent bit a cycle in the square-and-multiply loop for
// ^) and pushes the result; the last character adds flush, answer pop, clear.
// One character is worked on at a time; in_stall is high while the
// controller sequences. A finished answer holds under out_stall while the
// next characters are taken; only the next answer pop waits for it to go.
// Reset clears the stack pointer, the pending number and the status; the
// stack memory itself is never cleared.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         ch,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] answer,
  output logic [1:0]         status
);

  pee_pkg::cmd_t cmd;
  pee_pkg::sts_t sts;
  logic [7:0]    ch_q;
  logic [31:0]   answer_q;

  pee_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_last(last),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .ch_q(ch_q), .sts(sts), .cmd(cmd)
  );

  pee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .ch(ch), .sts(sts), .ch_q(ch_q),
    .answer_q(answer_q), .status_q(status)
  );

  assign answer = $signed(answer_q);

endmodule

// ----- design/pee_alu.sv -----
// ----------------------------------------------------------------------------
// Postfix evaluator arithmetic unit
// Iterative divide (one quotient bit a cycle) and square-and-multiply power
// (one exponent bit a cycle, two registered multiplies per step).
// ----------------------------------------------------------------------------
module pee_alu (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pee_pkg::op_t      op,
  input  logic [31:0]       left,
  input  logic [31:0]       right,
  output logic              busy,
  output logic              div_zero,
  output logic [31:0]       result
);

  typedef enum logic [1:0] {A_IDLE, A_DIV, A_POW} astate_t;

  astate_t     state;
  logic [5:0]  cnt;
  logic [31:0] rem, quo, dvs, base, expo, acc;
  logic        negq;
  logic [32:0] trial;
  logic [31:0] mul_a, mul_b;
  logic [31:0] mag_l, mag_r;

  assign mag_l = left[31]  ? 32'(0 - left)  : left;
  assign mag_r = right[31] ? 32'(0 - right) : right;
  assign trial = {rem, quo[31]} - {1'b0, dvs};
  assign mul_a = acc * base;
  assign mul_b = base * base;
  assign busy  = (state != A_IDLE);

  // start an operation, or run one step of divide or power per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (start) begin
            div_zero <= 1'b0;
            unique case (op)
              pee_pkg::OP_ADD: result <= left + right;
              pee_pkg::OP_SUB: result <= left - right;
              pee_pkg::OP_MUL: result <= 32'(left * right);
              pee_pkg::OP_DIV: begin
                div_zero <= (right == 32'd0);
                rem   <= 32'd0;
                quo   <= mag_l;
                dvs   <= mag_r;
                negq  <= left[31] ^ right[31];
                cnt   <= 6'd0;
                state <= (right == 32'd0) ? A_IDLE : A_DIV;
              end
              default: begin
                if (right[31]) begin
                  if (left == 32'd1) result <= 32'd1;
                  else if (left == 32'hFFFF_FFFF)
                    result <= right[0] ? 32'hFFFF_FFFF : 32'd1;
                  else result <= 32'd0;
                end else begin
                  acc   <= 32'd1;
                  base  <= left;
                  expo  <= right;
                  cnt   <= 6'd0;
                  state <= A_POW;
                end
              end
            endcase
          end
        end
        A_DIV: begin
          if (!trial[32]) rem <= trial[31:0];
          else rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], ~trial[32]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd32) begin
            result <= negq ? 32'(0 - quo) : quo;
            state  <= A_IDLE;
          end
        end
        A_POW: begin
          if (expo == 32'd0) begin
            result <= acc;
            state  <= A_IDLE;
          end else begin
            if (expo[0]) acc <= mul_a;
            base <= mul_b;
            expo <= {1'b0, expo[31:1]};
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

// ----- design/pee_datapath.sv -----
// ----------------------------------------------------------------------------
// Postfix evaluator datapath
// Operand stack memory, number accumulator, sticky status and result register.
// ----------------------------------------------------------------------------
module pee_datapath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  pee_pkg::cmd_t     cmd,
  input  logic [7:0]        ch,
  output pee_pkg::sts_t     sts,
  output logic [7:0]        ch_q,
  output logic [31:0]       answer_q,
  output logic [1:0]        status_q
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [31:0]   mem [STACK_DEPTH];
  logic [DW-1:0] depth;
  logic [31:0]   accum, rd_q, right_q, left_q, alu_res;
  logic [1:0]    err;
  logic          pending_q;
  logic          pop_any, push_any, alu_busy, alu_dz;
  logic          pop_r_d, pop_l_d, pop_ans_d, empty_d;
  logic [31:0]   push_val;
  logic [AW-1:0] top_idx;
  pee_pkg::op_t  op;

  assign pop_any  = cmd.pop_r | cmd.pop_l | cmd.pop_ans;
  assign push_any = (cmd.flush & pending_q) | (cmd.push_res & ~alu_dz);
  assign push_val = cmd.flush ? accum : alu_res;
  assign top_idx  = AW'(depth - DW'(1));
  assign sts.busy = alu_busy;
  assign sts.skip_push = alu_dz;

  always_comb begin
    unique case (ch_q)
      pee_pkg::CH_ADD: op = pee_pkg::OP_ADD;
      pee_pkg::CH_SUB: op = pee_pkg::OP_SUB;
      pee_pkg::CH_MUL: op = pee_pkg::OP_MUL;
      pee_pkg::CH_DIV: op = pee_pkg::OP_DIV;
      default:         op = pee_pkg::OP_POW;
    endcase
  end

  pee_alu u_alu (
    .clk(clk), .rst(rst), .start(cmd.start), .op(op),
    .left(left_q), .right(right_q),
    .busy(alu_busy), .div_zero(alu_dz), .result(alu_res)
  );

  // stack memory write and registered read of the top entry
  always_ff @(posedge clk) begin
    if (push_any && depth != DW'(STACK_DEPTH)) mem[depth[AW-1:0]] <= push_val;
    rd_q <= mem[top_idx];
  end

  // delay the pop commands to line up with the registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      pop_r_d   <= 1'b0;
      pop_l_d   <= 1'b0;
      pop_ans_d <= 1'b0;
      empty_d   <= 1'b1;
    end else begin
      pop_r_d   <= cmd.pop_r;
      pop_l_d   <= cmd.pop_l;
      pop_ans_d <= cmd.pop_ans;
      empty_d   <= (depth == '0);
    end
  end

  // stack pointer, accumulator, status
  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      accum     <= '0;
      pending_q <= 1'b0;
      err       <= pee_pkg::ST_OK;
    end else if (cmd.clear) begin
      depth     <= '0;
      accum     <= '0;
      pending_q <= 1'b0;
      err       <= pee_pkg::ST_OK;
    end else begin
      if (cmd.digit) begin
        accum     <= 32'(accum * 32'd10) + 32'(ch_q - pee_pkg::CH_ZERO);
        pending_q <= 1'b1;
      end
      if (cmd.flush) begin
        pending_q <= 1'b0;
        accum     <= '0;
      end
      if (push_any) begin
        if (depth == DW'(STACK_DEPTH)) begin
          if (err == pee_pkg::ST_OK) err <= pee_pkg::ST_OVER;
        end else depth <= depth + DW'(1);
      end
      if (pop_any) begin
        if (depth == '0) begin
          if (err == pee_pkg::ST_OK) err <= pee_pkg::ST_UNDER;
        end else depth <= depth - DW'(1);
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (cmd.take) ch_q <= ch;
    if (pop_r_d) right_q <= empty_d ? 32'd0 : rd_q;
    if (pop_l_d) left_q  <= empty_d ? 32'd0 : rd_q;
    if (pop_ans_d) begin
      answer_q <= empty_d ? 32'd0 : rd_q;
      status_q <= err;
    end
  end

endmodule

// ----- design/pee_ctrl.sv -----
// ----------------------------------------------------------------------------
// Postfix evaluator controller
// Sequences flush, pops, arithmetic, push and the final answer pop.
// ----------------------------------------------------------------------------
module pee_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  logic [7:0]     ch_q,
  input  pee_pkg::sts_t  sts,
  output pee_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_POPR, S_POPL, S_LOAD, S_START, S_WAIT, S_PUSH,
    S_FLUSH, S_ANS, S_CLEAR
  } state_t;

  state_t state;
  logic   last_q, is_op, is_digit;

  assign is_digit = (ch_q >= pee_pkg::CH_ZERO) && (ch_q <= pee_pkg::CH_NINE);
  assign is_op = (ch_q == pee_pkg::CH_ADD) || (ch_q == pee_pkg::CH_SUB) ||
                 (ch_q == pee_pkg::CH_MUL) || (ch_q == pee_pkg::CH_DIV) ||
                 (ch_q == pee_pkg::CH_POW);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.take = (state == S_IDLE) && in_valid && !in_stall;
    unique case (state)
      S_DECODE: begin
        cmd.digit = is_digit;
        cmd.flush = !is_digit;
      end
      S_POPR:  cmd.pop_r = 1'b1;
      S_POPL:  cmd.pop_l = 1'b1;
      S_START: cmd.start = 1'b1;
      S_PUSH:  cmd.push_res = 1'b1;
      S_FLUSH: cmd.flush = 1'b1;
      S_ANS:   cmd.pop_ans = 1'b1;
      S_CLEAR: cmd.clear = 1'b1;
      default: ;
    endcase
  end

  // advance the sequence and hold the result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd.take) begin
          last_q <= in_last;
          state  <= S_DECODE;
        end
        S_DECODE: state <= is_op ? S_POPR : (last_q ? S_FLUSH : S_IDLE);
        S_POPR:   state <= S_POPL;
        S_POPL:   state <= S_LOAD;
        S_LOAD:   state <= S_START;
        S_START:  state <= S_WAIT;
        S_WAIT:   if (!sts.busy) state <= S_PUSH;
        S_PUSH:   state <= last_q ? S_FLUSH : S_IDLE;
        // hold until the previous answer has gone
        S_FLUSH:  if (!(out_valid && out_stall)) state <= S_ANS;
        S_ANS:    state <= S_CLEAR;
        S_CLEAR: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/pee_checker.sv -----
// ----------------------------------------------------------------------------
// Postfix evaluator port checker
// Watches the top level ports for handshake and result sanity.
// ----------------------------------------------------------------------------
module pee_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] answer,
  input logic [1:0]  status
);

  // status code is never the unused value
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(answer) && $stable(status))
    else $error("result changed under stall");

  // one character at a time: input stalls right after a transaction
  a_block: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("input not stalled");

  // a result does not rise right after an accepted character
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid)) else $error("result too early");

endmodule

bind postfix_expression_evaluator pee_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .answer(answer), .status(status)
);

// ----- bench/tb_postfix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// Postfix expression evaluator testbench
// Streams expression characters with random gaps, predicts the answer and
// status of each expression and checks every output transaction in order.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator;

  localparam int DEPTH = 64;
  localparam int N_ITEMS = 1800;

  typedef struct packed {
    logic [7:0] c;
    logic       l;
    logic       chk;
    logic [31:0] ans;
    logic [1:0]  st;
  } row_t;

  typedef struct packed {
    logic [31:0] ans;
    logic [1:0]  st;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] ch = 8'd0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] answer;
  logic [1:0] status;

  // Predictor state
  logic [31:0] eval_stack [DEPTH];
  int          eval_depth;
  logic [31:0] eval_accum;
  bit          eval_pending;
  logic [1:0]  eval_status;

  res_t answer_q [$];
  row_t directed [$];
  int   fails = 0;
  int   sent = 0;
  bit   stim_done = 1'b0;

  postfix_expression_evaluator #(.STACK_DEPTH(DEPTH)) u_dut (
    .clk, .rst, .in_valid, .in_stall, .ch, .last,
    .out_valid, .out_stall, .answer, .status
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void note_err(logic [1:0] code);
    if (eval_status == pee_pkg::ST_OK) eval_status = code;
  endfunction

  function automatic void push_val(logic [31:0] v);
    if (eval_depth >= DEPTH) begin
      note_err(pee_pkg::ST_OVER);
    end else begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end
  endfunction

  function automatic logic [31:0] pop_val();
    if (eval_depth == 0) begin
      note_err(pee_pkg::ST_UNDER);
      return 32'd0;
    end
    eval_depth--;
    return eval_stack[eval_depth];
  endfunction

  function automatic logic [31:0] power_of(logic [31:0] b, logic [31:0] e);
    logic [31:0] r;
    r = 32'd1;
    if (e[31]) begin
      if (b == 32'd1) return 32'd1;
      if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    while (e != 0) begin
      if (e[0]) r = r * b;
      b = b * b;
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic void flush_num();
    if (eval_pending) begin
      push_val(eval_accum);
      eval_pending = 1'b0;
      eval_accum = 32'd0;
    end
  endfunction

  // Advance the predictor by one character; queue an answer on last
  function automatic void evaluate_char(logic [7:0] c, logic l);
    logic [31:0] rv, lv, ma, mb, q;
    res_t r;
    if (c >= pee_pkg::CH_ZERO && c <= pee_pkg::CH_NINE) begin
      eval_accum = eval_accum * 32'd10 + 32'(c - pee_pkg::CH_ZERO);
      eval_pending = 1'b1;
    end else begin
      flush_num();
      if (c == pee_pkg::CH_ADD || c == pee_pkg::CH_SUB || c == pee_pkg::CH_MUL ||
          c == pee_pkg::CH_DIV || c == pee_pkg::CH_POW) begin
        rv = pop_val();
        lv = pop_val();
        case (c)
          pee_pkg::CH_ADD: push_val(lv + rv);
          pee_pkg::CH_SUB: push_val(lv - rv);
          pee_pkg::CH_MUL: push_val(lv * rv);
          pee_pkg::CH_DIV: begin
            if (rv != 0) begin
              ma = lv[31] ? -lv : lv;
              mb = rv[31] ? -rv : rv;
              q = ma / mb;
              push_val((lv[31] != rv[31]) ? -q : q);
            end
          end
          default: push_val(power_of(lv, rv));
        endcase
      end
    end
    if (l) begin
      flush_num();
      r.ans = pop_val();
      r.st = eval_status;
      answer_q.push_back(r);
      eval_depth = 0;
      eval_accum = 32'd0;
      eval_pending = 1'b0;
      eval_status = pee_pkg::ST_OK;
    end
  endfunction

  // Hold one transaction until accepted, after a random gap
  task automatic send_char(logic [7:0] c, logic l);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    evaluate_char(c, l);
    sent++;
  endtask

  task automatic send_num(logic [31:0] v);
    string s;
    s = $sformatf("%0d", v);
    foreach (s[i]) send_char(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0: return pee_pkg::CH_ADD;
      1: return pee_pkg::CH_SUB;
      2: return pee_pkg::CH_MUL;
      3: return pee_pkg::CH_DIV;
      default: return pee_pkg::CH_POW;
    endcase
  endfunction

  function automatic void add_row(string s, bit chk, logic [31:0] a, logic [1:0] st);
    row_t r;
    foreach (s[i]) begin
      r.c = s[i];
      r.l = (i == s.len() - 1);
      r.chk = chk && r.l;
      r.ans = a;
      r.st = st;
      directed.push_back(r);
    end
  endfunction

  // Stimulus
  initial begin
    int k;
    eval_depth = 0;
    eval_accum = 0;
    eval_pending = 0;
    eval_status = pee_pkg::ST_OK;
    // directed table: typed expectation only where obvious
    add_row("5", 1, 32'd5, pee_pkg::ST_OK);
    add_row(" ", 1, 32'd0, pee_pkg::ST_UNDER);
    add_row("+", 1, 32'd0, pee_pkg::ST_UNDER);
    add_row("4294967295", 1, 32'hFFFF_FFFF, pee_pkg::ST_OK);
    add_row("4294967296", 1, 32'd0, pee_pkg::ST_OK);
    add_row("7 0/", 1, 32'd0, pee_pkg::ST_UNDER);
    add_row("2 3^", 0, 0, 0);
    add_row("9 4-", 0, 0, 0);
    add_row("6 7*", 0, 0, 0);
    add_row("7 2 /", 0, 0, 0);
    add_row("5 0^", 1, 32'd1, pee_pkg::ST_OK);
    add_row("\xff\x80a", 1, 32'd0, pee_pkg::ST_UNDER);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      send_char(directed[i].c, directed[i].l);
      // typed expectation stands in for the predicted one
      if (directed[i].chk)
        answer_q[answer_q.size() - 1] = {directed[i].ans, directed[i].st};
    end
    // special signed cases through the predictor
    send_num(32'd2147483648); send_char(" ", 0); send_num(0); send_char(" ", 0);
    send_num(1); send_char(pee_pkg::CH_SUB, 0); send_char(pee_pkg::CH_SUB, 0);
    send_num(1); send_char(pee_pkg::CH_SUB, 0); send_char(pee_pkg::CH_DIV, 1);
    send_num(0); send_char(" ", 0); send_num(1); send_char(pee_pkg::CH_SUB, 0);
    send_num(0); send_char(" ", 0); send_num(3); send_char(pee_pkg::CH_SUB, 0);
    send_char(pee_pkg::CH_POW, 1);
    // overflow: push past the stack depth
    for (int i = 0; i < DEPTH + 2; i++) send_char(i[0] ? "1" : " ", i == DEPTH * 2);
    for (int i = 0; i < DEPTH + 2; i++) begin
      send_char("1", 0);
      send_char(" ", i == DEPTH + 1);
    end
    // random expressions, mostly well formed
    while (sent < N_ITEMS) begin
      if (($urandom & 7) == 0) begin
        k = $urandom_range(1, 8);
        repeat (k) send_char($urandom_range(0, 255), ($urandom & 3) == 0);
        send_char($urandom_range(0, 255), 1'b1);
      end else begin
        k = $urandom_range(1, 5);
        send_num($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20));
        for (int j = 0; j < k; j++) begin
          send_char(" ", 0);
          send_num($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20));
          send_char(rand_op(), 0);
        end
        send_char(($urandom & 1) ? " " : "0", 1'b1);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Drive output stall: each result waits a drawn number of cycles
  initial begin
    int w;
    forever begin
      w = $urandom_range(0, 7);
      out_stall <= (w != 0);
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (w != 0) begin
        repeat (w - 1) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Check each output transaction against the oldest expectation
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        $error("answer with no expectation: %h", answer);
        fails++;
      end else begin
        e = answer_q.pop_front();
        if (answer !== e.ans) begin
          $error("answer expected %h actual %h", e.ans, answer);
          fails++;
        end
        if (status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status);
          fails++;
        end
      end
    end
  end

  // Finish once drained
  initial begin
    wait (stim_done);
    wait (answer_q.size() == 0);
    repeat (100) @(posedge clk);
    if (fails == 0 && answer_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
design/pee_pkg.sv
design/pee_alu.sv
design/pee_datapath.sv
design/pee_ctrl.sv
design/postfix_expression_evaluator.sv
design/pee_checker.sv
bench/tb_postfix_expression_evaluator.sv
